// ----- sv/prq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg : ready-queue scheduler shared definitions
// Sizes, field widths, operation and status codes.
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int LEVELS   = 8;
	localparam int THREADS  = 16;
	localparam int THREAD_W = 4;
	localparam int LEVEL_W  = 3;

	typedef logic [THREAD_W-1:0] tid_t;
	typedef logic [LEVEL_W-1:0]  lvl_t;

	typedef enum logic [1:0] {
		FN_PUSH   = 2'd0,
		FN_SCHED  = 2'd1,
		FN_REMOVE = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_QUEUED = 2'd2,
		ST_ALREADY    = 2'd3
	} status_t;

	// one write port and one registered read port of a link memory
	typedef struct packed {
		logic we;
		tid_t waddr;
		tid_t wdata;
		tid_t raddr;
	} link_req_t;

endpackage

// ----- sv/prq_link_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_link_ram : thread link memory
// One entry per thread, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prq_link_ram (
	input  logic               clk,
	input  prq_pkg::link_req_t req,
	output prq_pkg::tid_t      rdata
);
	import prq_pkg::*;

	tid_t mem [THREADS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

// ----- sv/priority_ready_queue_scheduler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top : multilevel priority ready queue
// Per-level FIFOs of thread ids kept as doubly linked lists in link memories.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------
//  in      | in_valid/in_stall  | func, thread_id, priority_req
//  out     | out_valid/out_stall| thread_out, status
//
//  Push, errors and the no-op code step through decide and result;
//  schedule and remove step through decide, link memory read, relink, result.
//  The link memory read/write ports are the shared resource the sequencer
//  steps through; one operation is in flight at a time.
//  After reset every level is empty and no thread is queued; no sweep needed.
//  A new item is taken while the previous result still waits on out_stall;
//  the finished result then waits in the done state until the output frees.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      func,
	input  prq_pkg::tid_t   thread_id,
	input  prq_pkg::lvl_t   priority_req,
	output logic            out_valid,
	input  logic            out_stall,
	output prq_pkg::tid_t   thread_out,
	output logic [1:0]      status
);
	import prq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_RD   = 5'b00100,
		S_LINK = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t  state_q;

	// operation being worked on
	func_t   func_q;
	tid_t    tid_q;
	lvl_t    lvl_q;    // level being unlinked from / pushed to
	tid_t    tgt_q;    // thread being unlinked
	tid_t    res_tid_q;
	status_t res_st_q;

	// per-level and per-thread bookkeeping
	logic [LEVELS-1:0]  nonempty_q;
	tid_t               head_q [LEVELS];
	tid_t               tail_q [LEVELS];
	logic [THREADS-1:0] qflag_q;
	lvl_t               qlevel_q [THREADS];

	// output register
	logic    out_valid_q;
	tid_t    out_tid_q;
	status_t out_st_q;

	link_req_t nx_req, pv_req;
	tid_t      nx_rd, pv_rd;

	logic req_ok;
	logic out_free;
	logic push_ok, push_link;
	logic args_bad, rem_ok;
	logic any_ready;
	lvl_t top_lvl;

	assign req_ok   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign thread_out = out_tid_q;
	assign status     = out_st_q;

	// range checks; these only bite when the sizes are below the field range
	assign args_bad  = (32'(lvl_q) >= LEVELS) || (32'(tid_q) >= THREADS);
	assign push_ok   = !args_bad && !qflag_q[tid_q];
	assign push_link = push_ok && nonempty_q[lvl_q];
	assign rem_ok    = !args_bad && qflag_q[tid_q] && (qlevel_q[tid_q] == lvl_q);

	// highest-priority non-empty level (index 0 first)
	always_comb begin
		any_ready = 1'b0;
		top_lvl   = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				any_ready = 1'b1;
				top_lvl   = LEVEL_W'(i);
			end
		end
	end

	// link memory control: push appends in EXEC, unlink relinks in LINK
	always_comb begin
		nx_req.raddr = tgt_q;
		pv_req.raddr = tgt_q;
		if (state_q == S_EXEC) begin
			nx_req.we    = (func_q == FN_PUSH) && push_link;
			nx_req.waddr = tail_q[lvl_q];
			nx_req.wdata = tid_q;
			pv_req.we    = (func_q == FN_PUSH) && push_link;
			pv_req.waddr = tid_q;
			pv_req.wdata = tail_q[lvl_q];
		end else begin
			// next[prev] = next, prev[next] = prev, unless at the ends
			nx_req.we    = (state_q == S_LINK) && (head_q[lvl_q] != tgt_q);
			nx_req.waddr = pv_rd;
			nx_req.wdata = nx_rd;
			pv_req.we    = (state_q == S_LINK) && (tail_q[lvl_q] != tgt_q);
			pv_req.waddr = nx_rd;
			pv_req.wdata = pv_rd;
		end
	end

	prq_link_ram u_next (
		.clk   (clk),
		.req   (nx_req),
		.rdata (nx_rd)
	);

	prq_link_ram u_prev (
		.clk   (clk),
		.req   (pv_req),
		.rdata (pv_rd)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			nonempty_q  <= '0;
			qflag_q     <= '0;
		end else begin
			// load a finished result, or drop the one just taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_ok) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (func_q)
						FN_PUSH: begin
							if (push_ok) begin
								nonempty_q[lvl_q] <= 1'b1;
								qflag_q[tid_q]    <= 1'b1;
							end
							state_q <= S_DONE;
						end
						FN_SCHED:  state_q <= any_ready ? S_RD : S_DONE;
						FN_REMOVE: state_q <= rem_ok ? S_RD : S_DONE;
						default:   state_q <= S_DONE;
					endcase
				end
				S_RD: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					// sole member of its level: level goes empty
					if (head_q[lvl_q] == tgt_q && tail_q[lvl_q] == tgt_q) begin
						nonempty_q[lvl_q] <= 1'b0;
					end
					qflag_q[tgt_q] <= 1'b0;
					state_q        <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_ok) begin
					func_q <= func_t'(func);
					tid_q  <= thread_id;
					lvl_q  <= priority_req;
				end
			end
			S_EXEC: begin
				unique case (func_q)
					FN_PUSH: begin
						if (push_ok) begin
							if (!nonempty_q[lvl_q]) begin
								head_q[lvl_q] <= tid_q;
							end
							tail_q[lvl_q]   <= tid_q;
							qlevel_q[tid_q] <= lvl_q;
							res_tid_q       <= tid_q;
							res_st_q        <= ST_OK;
						end else begin
							res_tid_q <= '0;
							res_st_q  <= args_bad ? ST_NOT_QUEUED : ST_ALREADY;
						end
					end
					FN_SCHED: begin
						lvl_q     <= top_lvl;
						tgt_q     <= head_q[top_lvl];
						res_tid_q <= any_ready ? head_q[top_lvl] : '0;
						res_st_q  <= any_ready ? ST_OK : ST_EMPTY;
					end
					FN_REMOVE: begin
						tgt_q     <= tid_q;
						res_tid_q <= rem_ok ? tid_q : '0;
						res_st_q  <= rem_ok ? ST_OK : ST_NOT_QUEUED;
					end
					default: begin
						res_tid_q <= '0;
						res_st_q  <= ST_OK;
					end
				endcase
			end
			S_LINK: begin
				if (head_q[lvl_q] == tgt_q) begin
					head_q[lvl_q] <= nx_rd;
				end
				if (tail_q[lvl_q] == tgt_q) begin
					tail_q[lvl_q] <= pv_rd;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_tid_q <= res_tid_q;
					out_st_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- dv/tb_priority_ready_queue_scheduler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler_top : ready-queue scheduler testbench
// Directed table, then biased random push/schedule/remove traffic. Every
// result is checked against its table expectation or an in-bench linked-list model.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler_top;
	import prq_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int N_DIR        = 25;
	// allows for the slowest op, the long receiver hold-off and the longest sender
	// gap; anything past this with no transfer is a hang
	localparam int IDLE_LIMIT   = 2000;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    in_valid     = 1'b0;
	logic    in_stall;
	func_t   func         = FN_NOP;
	tid_t    thread_id    = '0;
	lvl_t    priority_req = '0;
	logic    out_valid;
	logic    out_stall    = 1'b0;
	tid_t    thread_out;
	logic [1:0] status;

	priority_ready_queue_scheduler_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.thread_out   (thread_out),
		.status       (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Queue model: per-level doubly linked FIFOs, same layout as the block
	// ------------------------------------------------------------------------
	typedef struct packed {
		tid_t    th;
		status_t st;
	} rq_result_t;

	tid_t  rq_next  [THREADS];
	tid_t  rq_prev  [THREADS];
	tid_t  rq_head  [LEVELS];
	tid_t  rq_tail  [LEVELS];
	int    rq_count [LEVELS];
	bit    rq_queued[THREADS];
	lvl_t  rq_level [THREADS];

	rq_result_t pending_results[$];

	int errors       = 0;
	int results_seen = 0;
	int burst_left   = 0;
	int max_depth    = 0;
	int op_count [4];
	int st_count [4];

	function automatic void rq_unlink(input int lv, input tid_t t);
		tid_t p;
		tid_t n;
		p = rq_prev[t];
		n = rq_next[t];
		if (rq_head[lv] == t) rq_head[lv] = n;
		else rq_next[p] = n;
		if (rq_tail[lv] == t) rq_tail[lv] = p;
		else rq_prev[n] = p;
		if (rq_count[lv] > 0) rq_count[lv]--;
		rq_queued[t] = 1'b0;
	endfunction

	// applies one operation to the model and returns the result it gives;
	// level and thread fields are as wide as the tables, so never out of range
	function automatic void rq_apply(input func_t fn, input tid_t t, input lvl_t lv,
			output tid_t th, output status_t st);
		int found;
		tid_t h;
		th = '0;
		st = ST_OK;
		found = -1;
		case (fn)
			FN_PUSH: begin
				if (rq_queued[t]) begin
					st = ST_ALREADY;
				end else begin
					if (rq_count[lv] == 0) begin
						rq_head[lv] = t;
					end else begin
						rq_next[rq_tail[lv]] = t;
						rq_prev[t] = rq_tail[lv];
					end
					rq_tail[lv] = t;
					rq_count[lv]++;
					rq_queued[t] = 1'b1;
					rq_level[t] = lv;
					th = t;
				end
			end
			FN_SCHED: begin
				for (int i = LEVELS - 1; i >= 0; i--)
					if (rq_count[i] > 0) found = i;
				if (found < 0) begin
					st = ST_EMPTY;
				end else begin
					h = rq_head[found];
					rq_unlink(found, h);
					th = h;
				end
			end
			FN_REMOVE: begin
				if (!rq_queued[t] || rq_level[t] != lv) begin
					st = ST_NOT_QUEUED;
				end else begin
					rq_unlink(lv, t);
					th = t;
				end
			end
			default: ;  // spare code: no-op, ok
		endcase
	endfunction

	// Random traffic: mostly legal ops on the current queue contents,
	// a slice of deliberately bad requests and a slice of raw noise.
	function automatic void rq_pick(output func_t fn, output tid_t tid, output lvl_t lvl);
		int idle_ids[$];
		int busy_ids[$];
		int r;
		int push_cut;
		for (int k = 0; k < THREADS; k++)
			if (rq_queued[k]) busy_ids.push_back(k);
			else idle_ids.push_back(k);
		fn  = FN_SCHED;
		tid = tid_t'($urandom_range(0, THREADS - 1));
		lvl = lvl_t'($urandom_range(0, LEVELS - 1));
		r   = $urandom_range(0, 99);
		push_cut = (busy_ids.size() < 9) ? 55 : 35;
		if (r < 6) begin
			fn = func_t'($urandom_range(0, 3));
		end else if (r < 12 && busy_ids.size() != 0) begin
			tid = tid_t'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
			if ($urandom_range(0, 1) == 0) begin
				fn = FN_PUSH;
			end else begin
				fn  = FN_REMOVE;
				lvl = rq_level[tid] ^ lvl_t'($urandom_range(1, LEVELS - 1));
			end
		end else if (r < push_cut && idle_ids.size() != 0) begin
			fn  = FN_PUSH;
			tid = tid_t'(idle_ids[$urandom_range(0, idle_ids.size() - 1)]);
		end else if (r < 80 || busy_ids.size() == 0) begin
			fn = FN_SCHED;
		end else begin
			fn  = FN_REMOVE;
			tid = tid_t'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
			lvl = rq_level[tid];
		end
	endfunction

	// ------------------------------------------------------------------------
	// Input side: bursts with random gaps; call and return at a rising edge
	// ------------------------------------------------------------------------
	task automatic send_op(input func_t fn, input tid_t tid, input lvl_t lvl,
			input bit known, input tid_t e_th, input status_t e_st);
		rq_result_t res;
		tid_t th;
		status_t st;
		int gap;
		int depth;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid     <= 1'b1;
		func         <= fn;
		thread_id    <= tid;
		priority_req <= lvl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// transfer taken at this edge
		rq_apply(fn, tid, lvl, th, st);
		res.th = known ? e_th : th;
		res.st = known ? e_st : st;
		pending_results.push_back(res);
		op_count[fn]++;
		depth = 0;
		for (int k = 0; k < THREADS; k++) depth += rq_queued[k];
		if (depth > max_depth) max_depth = depth;
	endtask

	// sender goes quiet until the block has returned everything
	task automatic drain_pause();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Directed table. Known expectations only where obvious; the rest use
	// the model. Covers empty schedule, not-queued and wrong-level remove,
	// double push, the spare code, field extremes, and head/middle/tail/only
	// removal.
	// ------------------------------------------------------------------------
	typedef struct packed {
		func_t   fn;
		tid_t    tid;
		lvl_t    lvl;
		bit      known;
		tid_t    e_th;
		status_t e_st;
	} dir_row_t;

	dir_row_t dir_tab [N_DIR] = '{
		'{FN_SCHED,  4'd0,  3'd0, 1'b1, 4'd0,  ST_EMPTY},      // nothing queued yet
		'{FN_REMOVE, 4'd0,  3'd0, 1'b1, 4'd0,  ST_NOT_QUEUED},
		'{FN_REMOVE, 4'd15, 3'd7, 1'b1, 4'd0,  ST_NOT_QUEUED},
		'{FN_NOP,    4'd15, 3'd7, 1'b1, 4'd0,  ST_OK},
		'{FN_PUSH,   4'd15, 3'd7, 1'b1, 4'd15, ST_OK},         // lowest level
		'{FN_PUSH,   4'd15, 3'd0, 1'b1, 4'd0,  ST_ALREADY},
		'{FN_PUSH,   4'd0,  3'd0, 1'b1, 4'd0,  ST_OK},
		'{FN_PUSH,   4'd5,  3'd0, 1'b0, 4'd0,  ST_OK},
		'{FN_PUSH,   4'd9,  3'd0, 1'b0, 4'd0,  ST_OK},
		'{FN_REMOVE, 4'd5,  3'd3, 1'b1, 4'd0,  ST_NOT_QUEUED}, // wrong level
		'{FN_REMOVE, 4'd5,  3'd0, 1'b0, 4'd0,  ST_OK},         // middle of list
		'{FN_SCHED,  4'd0,  3'd0, 1'b0, 4'd0,  ST_OK},
		'{FN_SCHED,  4'd0,  3'd0, 1'b0, 4'd0,  ST_OK},
		'{FN_SCHED,  4'd0,  3'd0, 1'b0, 4'd0,  ST_OK},         // falls to level 7
		'{FN_SCHED,  4'd0,  3'd0, 1'b1, 4'd0,  ST_EMPTY},
		'{FN_PUSH,   4'd3,  3'd4, 1'b0, 4'd0,  ST_OK},
		'{FN_PUSH,   4'd4,  3'd4, 1'b0, 4'd0,  ST_OK},
		'{FN_PUSH,   4'd4,  3'd6, 1'b1, 4'd0,  ST_ALREADY},
		'{FN_REMOVE, 4'd4,  3'd4, 1'b0, 4'd0,  ST_OK},         // tail
		'{FN_REMOVE, 4'd3,  3'd4, 1'b0, 4'd0,  ST_OK},         // only entry
		'{FN_PUSH,   4'd7,  3'd2, 1'b0, 4'd0,  ST_OK},
		'{FN_PUSH,   4'd8,  3'd2, 1'b0, 4'd0,  ST_OK},
		'{FN_REMOVE, 4'd7,  3'd2, 1'b0, 4'd0,  ST_OK},         // head
		'{FN_SCHED,  4'd0,  3'd0, 1'b0, 4'd0,  ST_OK},
		'{FN_SCHED,  4'd0,  3'd0, 1'b1, 4'd0,  ST_EMPTY}
	};

	// ------------------------------------------------------------------------
	// Output side: stall pattern in modes (none / light / heavy), plus one
	// long hold-off mid-run so the block backs up and stalls its input
	// ------------------------------------------------------------------------
	initial begin
		int  mode_left;
		int  mode;
		int  hold_left;
		bit  hold_done;
		bit  stall_now;
		mode_left = 0;
		mode      = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && results_seen >= 500) begin
				hold_done = 1'b1;
				hold_left = 80;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (mode)
				0:       stall_now = 1'b0;
				1:       stall_now = ($urandom_range(0, 3) == 0);
				default: stall_now = ($urandom_range(0, 3) != 0);
			endcase
			if (hold_left != 0) begin
				stall_now = 1'b1;
				hold_left--;
			end
			out_stall <= stall_now;
		end
	end

	// result checker: each transfer against the oldest expectation
	always @(posedge clk) begin
		rq_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			st_count[status]++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: thread %0d status %0d",
					$time, thread_out, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (thread_out !== want.th) begin
					$display("%0t: thread_out mismatch: expected %0d, actual %0d",
						$time, want.th, thread_out);
					errors++;
				end
				if (status !== want.st) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.st, status);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			$time, IDLE_LIMIT, pending_results.size());
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		func_t fn;
		tid_t  tid;
		lvl_t  lvl;
		for (int k = 0; k < THREADS; k++) begin
			rq_next[k]   = '0;
			rq_prev[k]   = '0;
			rq_queued[k] = 1'b0;
			rq_level[k]  = '0;
		end
		for (int k = 0; k < LEVELS; k++) begin
			rq_head[k]  = '0;
			rq_tail[k]  = '0;
			rq_count[k] = 0;
		end
		for (int k = 0; k < 4; k++) begin
			op_count[k] = 0;
			st_count[k] = 0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_op(dir_tab[i].fn, dir_tab[i].tid, dir_tab[i].lvl,
				dir_tab[i].known, dir_tab[i].e_th, dir_tab[i].e_st);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) drain_pause();
			rq_pick(fn, tid, lvl);
			send_op(fn, tid, lvl, 1'b0, '0, ST_OK);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// catch any stray result after the last one
		repeat (12) @(posedge clk);

		$display("ops: %0d push, %0d schedule, %0d remove, %0d spare code; peak %0d queued",
			op_count[FN_PUSH], op_count[FN_SCHED], op_count[FN_REMOVE],
			op_count[FN_NOP], max_depth);
		$display("results: %0d ok, %0d empty, %0d not queued, %0d already queued; %0d errors",
			st_count[ST_OK], st_count[ST_EMPTY], st_count[ST_NOT_QUEUED],
			st_count[ST_ALREADY], errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- priority_ready_queue_scheduler_top.f -----
sv/prq_pkg.sv
sv/prq_link_ram.sv
sv/priority_ready_queue_scheduler_top.sv
dv/tb_priority_ready_queue_scheduler_top.sv
